@@ sv/wbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared types, constants and byte helpers for the wildcard byte stream
// search block.
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int PAT_WORDS  = 4;
    localparam int PAT_BYTES  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 6;
    localparam int CNT_W      = 32;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] WILD_BYTE    = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT0 = 3'd0,
        REG_PAT1 = 3'd1,
        REG_PAT2 = 3'd2,
        REG_PAT3 = 3'd3,
        REG_LEN  = 3'd4,
        REG_MODE = 3'd5
    } t_cfg_reg;

    // Bit order follows the mode register: bit0 no case, bit1 wildcard,
    // bit2 whole words.
    typedef struct packed {
        logic words;
        logic wild;
        logic nocase;
    } t_mode;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [7:0] upper_byte(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        return (c == 8'd0) || (c == 8'd9) || (c == NEWLINE_BYTE) || (c == 8'd32)
            || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64)
            || (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

@@ sv/wbs_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_cfg
// Configuration registers and the pattern aligned to the byte window:
// entry j of the aligned pattern faces window entry j (entry 0 newest).
// ----------------------------------------------------------------------------
module wbs_cfg #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output wbs_pkg::t_mode                  o_mode,
    output logic [7:0]                      o_apat [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0]          o_care,
    output logic [MAX_PATTERN:0]            o_lenhot,
    output logic [wbs_pkg::CNT_W-1:0]       o_lenm1
);
    import wbs_pkg::*;

    localparam int LW = (MAX_PATTERN < 2) ? 1 : $clog2(MAX_PATTERN + 1);

    logic [CFG_DATA_W-1:0]           r_pat_word [PAT_WORDS];
    logic [LEN_W-1:0]                r_len;
    t_mode                           r_mode;

    logic [PAT_WORDS*CFG_DATA_W-1:0] pat_flat;
    logic [LW-1:0]                   clen;
    logic [7:0]                      n_apat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]          n_care;
    logic [MAX_PATTERN:0]            n_lenhot;

    logic [7:0]                      r_apat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]          r_care;
    logic [MAX_PATTERN:0]            r_lenhot;
    logic [CNT_W-1:0]                r_lenm1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat_word[w] <= '0;
            end
            r_len  <= LEN_W'(1);
            r_mode <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
                    r_pat_word[i_cfg_index[1:0]] <= i_cfg_data;
                end
                REG_LEN: begin
                    r_len <= i_cfg_data[LEN_W-1:0];
                end
                REG_MODE: begin
                    r_mode <= t_mode'(i_cfg_data[2:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign pat_flat = {r_pat_word[3], r_pat_word[2], r_pat_word[1], r_pat_word[0]};

    // Clamp the length to 1..MAX_PATTERN and reverse the pattern onto the window.
    always_comb begin
        int         len_i;
        int         idx;
        logic [4:0] bi;
        len_i = int'(r_len);
        if (len_i < 1) begin
            len_i = 1;
        end
        if (len_i > MAX_PATTERN) begin
            len_i = MAX_PATTERN;
        end
        clen = LW'(len_i);
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx       = len_i - 1 - j;
            bi        = 5'(idx);
            n_care[j] = (j < len_i);
            n_apat[j] = (j < len_i && idx < PAT_BYTES) ? pat_flat[bi*8 +: 8] : 8'h00;
        end
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            n_lenhot[i] = (i == len_i);
        end
    end

    // Follows the configuration registers through a register of its own, in step
    // with the input register in front of the search stage.
    always_ff @(posedge i_clk) begin
        r_apat   <= n_apat;
        r_care   <= n_care;
        r_lenhot <= n_lenhot;
        r_lenm1  <= CNT_W'(clen) - CNT_W'(1);
    end

    assign o_mode   = r_mode;
    assign o_apat   = r_apat;
    assign o_care   = r_care;
    assign o_lenhot = r_lenhot;
    assign o_lenm1  = r_lenm1;

endmodule

@@ sv/wbs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_engine
// Search stage: byte window, counters, whole-word candidate and the result
// register. One item is processed per cycle unless an untaken result holds the input.
// ----------------------------------------------------------------------------
module wbs_engine #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    input  logic [7:0]                  i_s_data,
    input  logic                        i_s_first,
    input  logic                        i_s_last,
    input  wbs_pkg::t_mode              i_mode,
    input  logic [7:0]                  i_apat [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0]      i_care,
    input  logic [MAX_PATTERN:0]        i_lenhot,
    input  logic [wbs_pkg::CNT_W-1:0]   i_lenm1,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [wbs_pkg::CNT_W-1:0]   o_match_offset,
    output logic [wbs_pkg::CNT_W-1:0]   o_line_count,
    output logic [wbs_pkg::CNT_W-1:0]   o_line_start_offset
);
    import wbs_pkg::*;

    logic [7:0]       r_win [MAX_PATTERN];
    logic [CNT_W-1:0] r_bc, r_nl, r_ls;
    logic             r_pend, r_done;
    logic [CNT_W-1:0] r_pend_off, r_pend_nl, r_pend_ls;

    logic [7:0]       n_win [MAX_PATTERN];
    logic [CNT_W-1:0] n_bc, n_nl, n_ls;
    logic             n_pend, n_done;
    logic [CNT_W-1:0] n_pend_off, n_pend_nl, n_pend_ls;

    logic             r_out_valid, r_found;
    logic [CNT_W-1:0] r_off, r_lines, r_lstart;

    logic             fire;
    logic             emit, e_found;
    logic [CNT_W-1:0] e_off, e_lines, e_ls;

    logic [7:0]       win_new [MAX_PATTERN+1];
    logic [CNT_W-1:0] pos, nl_upd, ls_upd, start;
    logic             done_eff, pend_eff, hit, all_ok;
    logic [7:0]       bsel;

    assign o_s_ready = !r_out_valid || i_out_ready;
    assign fire      = i_s_valid && o_s_ready;

    always_comb begin
        logic [7:0] d;
        done_eff = i_s_first ? 1'b0 : r_done;
        pend_eff = i_s_first ? 1'b0 : r_pend;
        pos      = i_s_first ? '0 : r_bc;
        nl_upd   = i_s_first ? '0 : r_nl;
        ls_upd   = i_s_first ? '0 : r_ls;
        if (i_s_data == NEWLINE_BYTE) begin
            nl_upd = sat_inc(nl_upd);
            ls_upd = sat_inc(pos);
        end

        win_new[0] = i_s_data;
        for (int i = 1; i <= MAX_PATTERN; i++) begin
            win_new[i] = i_s_first ? 8'h00 : r_win[i-1];
        end

        all_ok = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            d = i_mode.nocase ? upper_byte(win_new[j]) : win_new[j];
            if (i_care[j] && !(i_mode.wild && i_apat[j] == WILD_BYTE) && i_apat[j] != d) begin
                all_ok = 1'b0;
            end
        end

        // Byte just before the match start, picked by the one-hot length.
        bsel = '0;
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            bsel = bsel | (win_new[i] & {8{i_lenhot[i]}});
        end

        hit   = (pos >= i_lenm1) && all_ok && (!i_mode.words || is_boundary(bsel));
        start = pos - i_lenm1;
    end

    always_comb begin
        n_win      = r_win;
        n_bc       = r_bc;
        n_nl       = r_nl;
        n_ls       = r_ls;
        n_pend     = r_pend;
        n_done     = r_done;
        n_pend_off = r_pend_off;
        n_pend_nl  = r_pend_nl;
        n_pend_ls  = r_pend_ls;
        emit       = 1'b0;
        e_found    = 1'b0;
        e_off      = '0;
        e_lines    = nl_upd;
        e_ls       = ls_upd;

        if (i_s_first) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                n_win[i] = 8'h00;
            end
            n_bc   = '0;
            n_nl   = '0;
            n_ls   = '0;
            n_pend = 1'b0;
            n_done = 1'b0;
        end

        if (!done_eff) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                n_win[i] = win_new[i];
            end
            n_bc   = sat_inc(pos);
            n_pend = 1'b0;
            if (pend_eff && is_boundary(i_s_data)) begin
                // Candidate closed by a boundary byte
                emit    = 1'b1;
                e_found = 1'b1;
                e_off   = r_pend_off;
                e_lines = r_pend_nl;
                e_ls    = r_pend_ls;
                n_done  = 1'b1;
            end else begin
                n_nl = nl_upd;
                n_ls = ls_upd;
                if (hit && (!i_mode.words || i_s_last)) begin
                    emit    = 1'b1;
                    e_found = 1'b1;
                    e_off   = start;
                    n_done  = 1'b1;
                end else begin
                    if (hit) begin
                        n_pend     = 1'b1;
                        n_pend_off = start;
                        n_pend_nl  = nl_upd;
                        n_pend_ls  = ls_upd;
                    end
                    if (i_s_last) begin
                        n_pend = 1'b0;
                        emit   = 1'b1;
                        n_done = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= 8'h00;
            end
            r_bc        <= '0;
            r_nl        <= '0;
            r_ls        <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_win  <= n_win;
                r_bc   <= n_bc;
                r_nl   <= n_nl;
                r_ls   <= n_ls;
                r_pend <= n_pend;
                r_done <= n_done;
            end
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_pend_off <= n_pend_off;
            r_pend_nl  <= n_pend_nl;
            r_pend_ls  <= n_pend_ls;
        end
        if (fire && emit) begin
            r_found  <= e_found;
            r_off    <= e_off;
            r_lines  <= e_lines;
            r_lstart <= e_ls;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_found             = r_found;
    assign o_match_offset      = r_off;
    assign o_line_count        = r_lines;
    assign o_line_start_offset = r_lstart;

    a_pend_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_done))
        else $error("candidate pending after search finished");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_s_last) |=> r_done)
        else $error("final byte did not end the search");

    a_done_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_done && !i_s_first) |=> ($stable(r_bc) && !r_out_valid) || $past(r_out_valid))
        else $error("item after result changed state");

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && emit) |=> (r_done && r_out_valid))
        else $error("result given without closing the search");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ls <= r_bc) && (r_nl <= r_bc))
        else $error("line counters ahead of byte counter");

endmodule

@@ sv/wildcard_byte_stream_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_stream_search
// Finds the first occurrence of a configured pattern, with optional '?'
// wildcards, case folding and whole-word matching, in a byte stream.
// ----------------------------------------------------------------------------
// Timing: an accepted item passes through the input register, then the window compare
//   into the result register, which drives the output.
// Throughput: one byte per cycle while the output is not held back; the window compare over
//   all pattern positions completes in the single search stage.
// Reset: synchronous; pattern registers return to zero, length to one, mode to
//   zero, and the stream state is cleared at once. No clearing pass.
module wildcard_byte_stream_search #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_first_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [wbs_pkg::CNT_W-1:0]       o_match_offset,
    output logic [wbs_pkg::CNT_W-1:0]       o_line_count,
    output logic [wbs_pkg::CNT_W-1:0]       o_line_start_offset,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wbs_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_data;
    logic                   r_in_first, r_in_last;
    logic                   eng_ready;

    t_mode                  mode;
    logic [7:0]             apat [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care;
    logic [MAX_PATTERN:0]   lenhot;
    logic [CNT_W-1:0]       lenm1;

    assign o_in_ready = !r_in_valid || eng_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Hold the item until the search stage takes it
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
    end

    wbs_cfg #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mode      (mode),
        .o_apat      (apat),
        .o_care      (care),
        .o_lenhot    (lenhot),
        .o_lenm1     (lenm1)
    );

    wbs_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_s_valid           (r_in_valid),
        .o_s_ready           (eng_ready),
        .i_s_data            (r_in_data),
        .i_s_first           (r_in_first),
        .i_s_last            (r_in_last),
        .i_mode              (mode),
        .i_apat              (apat),
        .i_care              (care),
        .i_lenhot            (lenhot),
        .i_lenm1             (lenm1),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_found             (o_found),
        .o_match_offset      (o_match_offset),
        .o_line_count        (o_line_count),
        .o_line_start_offset (o_line_start_offset)
    );

endmodule

@@ bench/wildcard_byte_stream_search_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_stream_search_test
// Self-checking bench for the byte stream search. Directed streams cover the
// option modes, length clamping, word edges and the stream marks. Random
// streams with embedded pattern copies follow under random settings. Every
// result is checked against a bench-side search model.
// ----------------------------------------------------------------------------
module wildcard_byte_stream_search_test;
    import wbs_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int WINDOW_DEPTH = PAT_BYTES + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [2:0] MODE_PLAIN  = 3'b000;
    localparam logic [2:0] MODE_NOCASE = 3'b001;
    localparam logic [2:0] MODE_WILD   = 3'b010;
    localparam logic [2:0] MODE_WORDS  = 3'b100;

    localparam logic [7:0] SPACE_BYTE = 8'd32;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] lines;
        logic [CNT_W-1:0] line_start;
    } t_search_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte = '0;
    logic                  i_first_byte = 1'b0;
    logic                  i_last_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [CNT_W-1:0]      o_match_offset;
    logic [CNT_W-1:0]      o_line_count;
    logic [CNT_W-1:0]      o_line_start_offset;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wildcard_byte_stream_search u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_data_byte         (i_data_byte),
        .i_first_byte        (i_first_byte),
        .i_last_byte         (i_last_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_found             (o_found),
        .o_match_offset      (o_match_offset),
        .o_line_count        (o_line_count),
        .o_line_start_offset (o_line_start_offset),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Search model state and its copy of the registers
    logic [7:0]       pat_bytes [PAT_BYTES];
    logic [LEN_W-1:0] pat_len;
    logic [2:0]       mode_bits;
    logic [7:0]       recent [WINDOW_DEPTH];
    logic [CNT_W-1:0] next_offset;
    logic [CNT_W-1:0] newlines;
    logic [CNT_W-1:0] cur_line_start;
    logic             held_valid;
    logic [CNT_W-1:0] held_offset;
    logic [CNT_W-1:0] held_lines;
    logic [CNT_W-1:0] held_line_start;
    logic             stream_closed;
    int               live_bytes = 0;

    t_search_report   reports_due [$];
    int               fault_count = 0;

    // Stimulus staging
    logic [7:0]       pat_stage [PAT_BYTES];
    logic [7:0]       stream_buf [$];
    int               burst_left = 0;
    int               gap_ceiling = 0;

    function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] v);
        return &v ? v : v + 1'b1;
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? {c[7:6], 1'b0, c[4:0]} : c;
    endfunction

    function automatic logic is_word_edge(input logic [7:0] c);
        logic alnum;
        alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        return c == 8'd0 || c == 8'd9 || c == NEWLINE_BYTE || c == SPACE_BYTE
            || (c >= 8'd33 && c <= 8'd126 && !alnum);
    endfunction

    function automatic void clear_stream_state();
        int k;
        for (k = 0; k < WINDOW_DEPTH; k++) recent[k] = 8'h00;
        next_offset     = '0;
        newlines        = '0;
        cur_line_start  = '0;
        held_valid      = 1'b0;
        held_offset     = '0;
        held_lines      = '0;
        held_line_start = '0;
        stream_closed   = 1'b0;
    endfunction

    function automatic void reset_model();
        int k;
        for (k = 0; k < PAT_BYTES; k++) begin
            pat_bytes[k] = 8'h00;
            pat_stage[k] = 8'h00;
        end
        pat_len   = LEN_W'(1);
        mode_bits = MODE_PLAIN;
        clear_stream_state();
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        int b;
        case (idx)
            REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
                for (b = 0; b < 8; b++) pat_bytes[int'(idx) * 8 + b] = data[8*b +: 8];
            end
            REG_LEN: begin
                pat_len = data[LEN_W-1:0];
            end
            REG_MODE: begin
                mode_bits = data[2:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_report(input logic found, input logic [CNT_W-1:0] offset,
                                       input logic [CNT_W-1:0] lines,
                                       input logic [CNT_W-1:0] line_start);
        t_search_report r;
        r.found      = found;
        r.offset     = offset;
        r.lines      = lines;
        r.line_start = line_start;
        reports_due.push_back(r);
        stream_closed = 1'b1;
    endfunction

    // Advance the search by one accepted byte and queue any result it causes
    function automatic void advance_search(input logic [7:0] d, input logic f, input logic l);
        logic [CNT_W-1:0] pos;
        logic [7:0]       got;
        logic             hit;
        int               len;
        int               k;
        if (f) clear_stream_state();
        live_bytes++;
        if (stream_closed) return;
        pos = next_offset;
        next_offset = bump32(next_offset);
        for (k = WINDOW_DEPTH - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = d;

        // A held whole-word candidate is settled by this byte, whatever the mode is now
        if (held_valid) begin
            held_valid = 1'b0;
            if (is_word_edge(d)) begin
                add_report(1'b1, held_offset, held_lines, held_line_start);
                return;
            end
        end

        if (d == NEWLINE_BYTE) begin
            newlines = bump32(newlines);
            cur_line_start = bump32(pos);
        end

        if (pat_len == 0) len = 1;
        else if (pat_len > PAT_BYTES) len = PAT_BYTES;
        else len = int'(pat_len);

        if (pos >= CNT_W'(len - 1)) begin
            hit = 1'b1;
            for (k = 0; k < len; k++) begin
                got = recent[len - 1 - k];
                if (mode_bits[0]) got = fold_upper(got);
                if (!(mode_bits[1] && pat_bytes[k] == WILD_BYTE) && pat_bytes[k] != got)
                    hit = 1'b0;
            end
            if (hit && mode_bits[2] && !is_word_edge(recent[len])) hit = 1'b0;
            if (hit) begin
                if (!mode_bits[2] || l) begin
                    add_report(1'b1, pos - CNT_W'(len - 1), newlines, cur_line_start);
                    return;
                end
                held_valid      = 1'b1;
                held_offset     = pos - CNT_W'(len - 1);
                held_lines      = newlines;
                held_line_start = cur_line_start;
            end
        end

        if (l) begin
            held_valid = 1'b0;
            add_report(1'b0, '0, newlines, cur_line_start);
        end
    endfunction

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_search_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                log_fault($sformatf("unexpected result: found=%0d offset=%0d lines=%0d ls=%0d",
                    o_found, o_match_offset, o_line_count, o_line_start_offset));
            end else begin
                want = reports_due.pop_front();
                if (o_found !== want.found || o_match_offset !== want.offset
                        || o_line_count !== want.lines
                        || o_line_start_offset !== want.line_start) begin
                    log_fault($sformatf(
                        "mismatch: expected found=%0d offset=%0d lines=%0d ls=%0d, got %0d %0d %0d %0d",
                        want.found, want.offset, want.lines, want.line_start,
                        o_found, o_match_offset, o_line_count, o_line_start_offset));
                end
            end
        end
    end

    // Receiver stalls follow a 32-bit mask, stepped through bit by bit and reloaded after its last bit
    logic [31:0] stall_mask = '1;
    logic [4:0]  stall_pos = '0;

    always @(posedge i_clk) begin
        stall_pos   <= stall_pos + 1'b1;
        i_out_ready <= stall_mask[stall_pos];
        if (stall_pos == 5'd31) begin
            case ($urandom_range(0, 3))
                0: stall_mask <= '1;
                1: stall_mask <= $urandom | 32'd1;
                2: stall_mask <= ($urandom & $urandom) | 32'd1;
                default: stall_mask <= $urandom | $urandom | 32'd1;
            endcase
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] d, input logic f, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_first_byte <= f;
        i_last_byte  <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_search(d, f, l);
    endtask

    task automatic send_stream(input logic mark_first, input logic mark_last);
        int i;
        for (i = 0; i < stream_buf.size(); i++)
            send_byte(stream_buf[i], mark_first && i == 0,
                      mark_last && i == stream_buf.size() - 1);
    endtask

    task automatic send_text(input string s, input logic mark_first, input logic mark_last);
        int i;
        stream_buf.delete();
        for (i = 0; i < s.len(); i++) stream_buf.push_back(s[i]);
        send_stream(mark_first, mark_last);
    endtask

    // Drop valid, drain all results, then let bytes with no result leave the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_setting(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pack_word(input int w);
        logic [CFG_DATA_W-1:0] word;
        int b;
        for (b = 0; b < 8; b++) word[8*b +: 8] = pat_stage[8*w + b];
        return word;
    endfunction

    task automatic load_settings(input logic [LEN_W-1:0] len, input logic [2:0] mode);
        logic [CFG_DATA_W-1:0] word;
        settle();
        write_reg(REG_PAT0, pack_word(0));
        write_reg(REG_PAT1, pack_word(1));
        write_reg(REG_PAT2, pack_word(2));
        write_reg(REG_PAT3, pack_word(3));
        // Fill the unused upper bits with noise
        word = {$urandom, $urandom};
        word[LEN_W-1:0] = len;
        write_reg(REG_LEN, word);
        word = {$urandom, $urandom};
        word[2:0] = mode;
        write_reg(REG_MODE, word);
        if ($urandom_range(0, 7) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void stage_text(input string s);
        int i;
        for (i = 0; i < PAT_BYTES; i++) pat_stage[i] = (i < s.len()) ? s[i] : 8'h00;
    endfunction

    function automatic logic [7:0] pick_edge_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd9;
            2: return NEWLINE_BYTE;
            3, 4: return SPACE_BYTE;
            5: return 8'($urandom_range(58, 64));
            6: return 8'($urandom_range(33, 47));
            7: return 8'($urandom_range(91, 96));
            8: return 8'($urandom_range(123, 126));
            default: return ".";
        endcase
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(8'h41, 8'h5A));
            3, 4: return WILD_BYTE;
            5: return pick_edge_byte();
            6: return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom);
        endcase
    endfunction

    // Turn a pattern byte into a stream byte that still matches it
    function automatic logic [7:0] disguise(input logic [7:0] p);
        if (mode_bits[1] && p == WILD_BYTE) return 8'($urandom);
        if (mode_bits[0] && p >= "A" && p <= "Z" && $urandom_range(0, 1)) return p | 8'h20;
        return p;
    endfunction

    function automatic logic [7:0] pick_filler_byte(input int len_eff);
        case ($urandom_range(0, 9))
            0, 1, 2: return fold_upper(8'($urandom_range(8'h61, 8'h7A)))
                            | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            3, 4: return pick_edge_byte();
            5: return NEWLINE_BYTE;
            6, 7: return disguise(pat_stage[$urandom_range(0, len_eff - 1)]);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_stream(input int len_eff);
        int style;
        int at;
        int j;
        stream_buf.delete();
        style = $urandom_range(0, 9);
        if (style == 0) begin
            repeat ($urandom_range(1, 24)) stream_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 12)) stream_buf.push_back(pick_filler_byte(len_eff));
            if (style != 9) begin
                if ($urandom_range(0, 1)) stream_buf.push_back(pick_edge_byte());
                at = stream_buf.size();
                for (j = 0; j < len_eff; j++) stream_buf.push_back(disguise(pat_stage[j]));
                // Change one byte of the copy
                if (style == 8) begin
                    j = at + $urandom_range(0, len_eff - 1);
                    stream_buf[j] = stream_buf[j] ^ 8'($urandom_range(1, 255));
                end
                if ($urandom_range(0, 1)) stream_buf.push_back(pick_edge_byte());
            end
            repeat ($urandom_range(0, 8)) stream_buf.push_back(pick_filler_byte(len_eff));
        end
        if (stream_buf.size() == 0) stream_buf.push_back(pick_filler_byte(len_eff));
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 49))
            0: return LEN_W'(0);
            1: return LEN_W'($urandom_range(33, 63));
            2, 3, 4: return LEN_W'($urandom_range(17, 32));
            5, 6, 7, 8, 9, 10, 11, 12, 13, 14: return LEN_W'($urandom_range(7, 16));
            default: return LEN_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic test_unmarked_stream();
        // Reset settings: one zero byte, no options
        send_byte("x", 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte("q", 1'b0, 1'b1);
        send_byte("q", 1'b1, 1'b1);
    endtask

    task automatic test_length_bounds();
        stage_text("Z");
        load_settings(LEN_W'(0), MODE_PLAIN);
        send_text("aZ", 1'b1, 1'b1);
    endtask

    task automatic test_whole_word();
        stage_text("AB");
        load_settings(LEN_W'(2), MODE_WORDS);
        send_text("AB ", 1'b1, 1'b1);
        send_text("x.AB", 1'b1, 1'b1);
        send_text("AAB ", 1'b1, 1'b1);
    endtask

    task automatic test_case_fold();
        stage_text("AB");
        load_settings(LEN_W'(2), MODE_NOCASE | MODE_WORDS);
        send_text("\nab\n", 1'b1, 1'b1);
    endtask

    task automatic test_pending_mode_change();
        stage_text("AB");
        load_settings(LEN_W'(2), MODE_WORDS);
        send_text("AB", 1'b1, 1'b0);
        load_settings(LEN_W'(2), MODE_PLAIN);
        send_text("!", 1'b0, 1'b1);
    endtask

    task automatic test_wildcard();
        stage_text("A?C");
        load_settings(LEN_W'(3), MODE_WILD);
        send_text("A\377C", 1'b1, 1'b1);
        load_settings(LEN_W'(3), MODE_PLAIN);
        send_text("A\377C", 1'b1, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [LEN_W-1:0] len_reg;
        logic [2:0]       mode;
        int               start_count;
        int               phase;
        int               len_eff;
        int               k;
        start_count = live_bytes;
        phase = 0;
        while (live_bytes - start_count < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    for (k = 0; k < PAT_BYTES; k++) pat_stage[k] = pick_pattern_byte();
                    len_reg = LEN_W'(32);
                    mode = MODE_NOCASE | MODE_WILD | MODE_WORDS;
                end
                1: begin
                    for (k = 0; k < PAT_BYTES; k++) pat_stage[k] = 8'hFF;
                    len_reg = LEN_W'(63);
                    mode = MODE_PLAIN;
                end
                2: begin
                    for (k = 0; k < PAT_BYTES; k++) pat_stage[k] = 8'h00;
                    len_reg = LEN_W'(0);
                    mode = MODE_NOCASE | MODE_WILD | MODE_WORDS;
                end
                default: begin
                    for (k = 0; k < PAT_BYTES; k++) pat_stage[k] = pick_pattern_byte();
                    len_reg = pick_length();
                    mode = 3'($urandom);
                end
            endcase
            gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            load_settings(len_reg, mode);
            if (len_reg == 0) len_eff = 1;
            else if (len_reg > PAT_BYTES) len_eff = PAT_BYTES;
            else len_eff = int'(len_reg);
            repeat ((len_eff > 16) ? 2 : $urandom_range(2, 5)) begin
                build_stream(len_eff);
                send_stream($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
            end
            phase++;
        end
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unmarked_stream();
        test_length_bounds();
        test_whole_word();
        test_case_fold();
        test_pending_mode_change();
        test_wildcard();
        test_random_streams();
        settle();
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/wbs_pkg.sv
sv/wbs_cfg.sv
sv/wbs_engine.sv
sv/wildcard_byte_stream_search.sv
bench/wildcard_byte_stream_search_test.sv
